// File: src/msr_pkg.sv
package msr_pkg;

    // default field width and reset modulus
    localparam int DEF_WIDTH   = 31;
    localparam int PRIME_RESET = 7;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_QINIT,
        OP_QSHIFT,
        OP_ZINIT,
        OP_ZINC,
        OP_MINIT,
        OP_IINIT,
        OP_IINC,
        OP_MSET,
        OP_RED,
        OP_EUL,
        OP_P34,
        OP_ZCHK,
        OP_POWC,
        OP_POWR,
        OP_POWT,
        OP_SQT,
        OP_SQT2,
        OP_POWB,
        OP_MRB,
        OP_MBB,
        OP_MTC,
        OP_FZERO1,
        OP_FZERO0,
        OP_FN,
        OP_FRES,
        OP_FR,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic res_one;
        logic res_pm1;
        logic p_lt2;
        logic p_eq2;
        logic p_mod3;
        logic n_zero;
        logic q_shift;
        logic z_ge_p;
        logic t_one;
        logic t2_one;
        logic i_lt_m;
    } status_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK,
        ST_WAIT,
        ST_ZERO,
        ST_EULER,
        ST_ROOT34,
        ST_QLOOP,
        ST_ZLOOP,
        ST_ZTEST,
        ST_SETUP_C,
        ST_SETUP_R,
        ST_SETUP_T,
        ST_OUTER,
        ST_SQ,
        ST_INNER,
        ST_IINC,
        ST_UPD_R,
        ST_UPD_C,
        ST_UPD_T,
        ST_MSET,
        ST_EMIT
    } st_t;

    // exponentiation unit states
    typedef enum logic [2:0] {
        PW_IDLE,
        PW_ONE,
        PW_ONE_WAIT,
        PW_TEST,
        PW_MUL,
        PW_MUL_WAIT,
        PW_SQ,
        PW_SQ_WAIT
    } pw_t;

endpackage

// File: src/msr_mulmod.sv
module msr_mulmod #(
    parameter int WIDTH = msr_pkg::DEF_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] p,
    output logic             done,
    output logic [WIDTH-1:0] res
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] sh_reg;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] p1;
    logic [WIDTH+1:0] p2;

    // one multiplier bit per cycle: acc = 2*acc + bit*a, brought back below p
    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0} + (sh_reg[WIDTH-1] ? {2'b00, a} : '0);
        p1  = {2'b00, p};
        p2  = {1'b0, p, 1'b0};
        if (sum >= p2)
        begin
            acc_next = WIDTH'(sum - p2);
        end
        else if (sum >= p1)
        begin
            acc_next = WIDTH'(sum - p1);
        end
        else
        begin
            acc_next = sum[WIDTH-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            sh_reg  <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            sh_reg  <= {sh_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

// File: src/msr_powmod.sv
module msr_powmod #(
    parameter int WIDTH = msr_pkg::DEF_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mul_mode,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] e,
    input  logic [WIDTH-1:0] p,
    output logic             done,
    output logic [WIDTH-1:0] res
);

    msr_pkg::pw_t     st_reg;
    msr_pkg::pw_t     st_next;
    logic             done_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] ex_reg;
    logic             mm_start;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic             mm_done;
    logic [WIDTH-1:0] mm_res;

    msr_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .p     (p),
        .done  (mm_done),
        .res   (mm_res)
    );

    // next state: square and multiply with the exponent taken from the low bit, or one product in mul_mode
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            msr_pkg::PW_IDLE:
            begin
                if (start)
                begin
                    st_next = mul_mode ? msr_pkg::PW_ONE : msr_pkg::PW_TEST;
                end
            end
            msr_pkg::PW_ONE:      st_next = msr_pkg::PW_ONE_WAIT;
            msr_pkg::PW_ONE_WAIT:
            begin
                if (mm_done)
                begin
                    st_next = msr_pkg::PW_IDLE;
                end
            end
            msr_pkg::PW_TEST:
            begin
                if (ex_reg == '0)
                begin
                    st_next = msr_pkg::PW_IDLE;
                end
                else if (ex_reg[0])
                begin
                    st_next = msr_pkg::PW_MUL;
                end
                else
                begin
                    st_next = msr_pkg::PW_SQ;
                end
            end
            msr_pkg::PW_MUL:      st_next = msr_pkg::PW_MUL_WAIT;
            msr_pkg::PW_MUL_WAIT:
            begin
                if (mm_done)
                begin
                    st_next = msr_pkg::PW_SQ;
                end
            end
            msr_pkg::PW_SQ:       st_next = msr_pkg::PW_SQ_WAIT;
            msr_pkg::PW_SQ_WAIT:
            begin
                if (mm_done)
                begin
                    st_next = msr_pkg::PW_TEST;
                end
            end
            default:              st_next = msr_pkg::PW_IDLE;
        endcase
    end

    // multiplier commands and operands
    always_comb
    begin
        mm_start = 1'b0;
        mm_a     = base_reg;
        mm_b     = base_reg;
        unique case (st_reg)
            msr_pkg::PW_ONE:
            begin
                mm_start = 1'b1;
                mm_b     = ex_reg;
            end
            msr_pkg::PW_MUL:
            begin
                mm_start = 1'b1;
                mm_a     = acc_reg;
            end
            msr_pkg::PW_MUL_WAIT:
            begin
                mm_a = acc_reg;
            end
            msr_pkg::PW_SQ:
            begin
                mm_start = 1'b1;
            end
            default:
            begin
                mm_start = 1'b0;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= msr_pkg::PW_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= ((st_reg == msr_pkg::PW_TEST) && (ex_reg == '0)) ||
                        ((st_reg == msr_pkg::PW_ONE_WAIT) && mm_done);
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if ((st_reg == msr_pkg::PW_IDLE) && start)
        begin
            base_reg <= a;
            ex_reg   <= e;
            acc_reg  <= WIDTH'(1);
        end
        else if (mm_done)
        begin
            if ((st_reg == msr_pkg::PW_ONE_WAIT) || (st_reg == msr_pkg::PW_MUL_WAIT))
            begin
                acc_reg <= mm_res;
            end
            else if (st_reg == msr_pkg::PW_SQ_WAIT)
            begin
                base_reg <= mm_res;
                ex_reg   <= {1'b0, ex_reg[WIDTH-1:1]};
            end
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

// File: src/msr_datapath.sv
module msr_datapath #(
    parameter int WIDTH = msr_pkg::DEF_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [WIDTH-1:0]  cfg_value,
    input  logic [WIDTH-1:0]  in_value,
    input  msr_pkg::cmd_t     cmd,
    output msr_pkg::status_t  status,
    output logic [WIDTH-1:0]  out_root,
    output logic              out_found
);

    localparam int SW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] p_reg;
    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] z_reg;
    logic [WIDTH-1:0] c_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] t_reg;
    logic [WIDTH-1:0] t2_reg;
    logic [WIDTH-1:0] b_reg;
    logic [SW-1:0]    s_reg;
    logic [SW-1:0]    m_reg;
    logic [SW-1:0]    i_reg;
    msr_pkg::op_t     dest_reg;
    logic [WIDTH-1:0] ans_root_reg;
    logic             ans_found_reg;
    logic [WIDTH-1:0] out_root_reg;
    logic             out_found_reg;

    logic             u_start;
    logic             u_mul;
    logic [WIDTH-1:0] u_a;
    logic [WIDTH-1:0] u_e;
    logic             u_done;
    logic [WIDTH-1:0] u_res;
    logic [WIDTH-1:0] half;
    logic [SW-1:0]    shamt;

    assign half  = (p_reg - WIDTH'(1)) >> 1;
    assign shamt = m_reg - i_reg - SW'(1);

    msr_powmod #(.WIDTH(WIDTH)) u_powmod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (u_start),
        .mul_mode (u_mul),
        .a        (u_a),
        .e        (u_e),
        .p        (p_reg),
        .done     (u_done),
        .res      (u_res)
    );

    // operand select for the exponentiation unit
    always_comb
    begin
        u_start = 1'b1;
        u_mul   = 1'b0;
        u_a     = n_reg;
        u_e     = half;
        unique case (cmd.op)
            msr_pkg::OP_RED:
            begin
                u_mul = 1'b1;
                u_a   = WIDTH'(1);
                u_e   = n_reg;
            end
            msr_pkg::OP_EUL:  u_e = half;
            msr_pkg::OP_P34:  u_e = (p_reg >> 2) + WIDTH'(1);
            msr_pkg::OP_ZCHK:
            begin
                u_a = z_reg;
                u_e = half;
            end
            msr_pkg::OP_POWC:
            begin
                u_a = z_reg;
                u_e = q_reg;
            end
            msr_pkg::OP_POWR: u_e = (q_reg >> 1) + WIDTH'(1);
            msr_pkg::OP_POWT: u_e = q_reg;
            msr_pkg::OP_SQT:
            begin
                u_mul = 1'b1;
                u_a   = t_reg;
                u_e   = t_reg;
            end
            msr_pkg::OP_SQT2:
            begin
                u_mul = 1'b1;
                u_a   = t2_reg;
                u_e   = t2_reg;
            end
            msr_pkg::OP_POWB:
            begin
                u_a = c_reg;
                u_e = WIDTH'(1) << shamt;
            end
            msr_pkg::OP_MRB:
            begin
                u_mul = 1'b1;
                u_a   = r_reg;
                u_e   = b_reg;
            end
            msr_pkg::OP_MBB:
            begin
                u_mul = 1'b1;
                u_a   = b_reg;
                u_e   = b_reg;
            end
            msr_pkg::OP_MTC:
            begin
                u_mul = 1'b1;
                u_a   = t_reg;
                u_e   = c_reg;
            end
            default:
            begin
                u_start = 1'b0;
            end
        endcase
    end

    // modulus register and writeback target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg    <= WIDTH'(msr_pkg::PRIME_RESET);
            dest_reg <= msr_pkg::OP_NONE;
        end
        else
        begin
            if (cfg_write)
            begin
                p_reg <= cfg_value;
            end
            if (u_start)
            begin
                dest_reg <= cmd.op;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            msr_pkg::OP_LOAD:   n_reg <= in_value;
            msr_pkg::OP_QINIT:
            begin
                q_reg <= p_reg - WIDTH'(1);
                s_reg <= '0;
            end
            msr_pkg::OP_QSHIFT:
            begin
                q_reg <= q_reg >> 1;
                s_reg <= s_reg + SW'(1);
            end
            msr_pkg::OP_ZINIT:  z_reg <= WIDTH'(2);
            msr_pkg::OP_ZINC:   z_reg <= z_reg + WIDTH'(1);
            msr_pkg::OP_MINIT:  m_reg <= s_reg;
            msr_pkg::OP_IINIT:  i_reg <= SW'(1);
            msr_pkg::OP_IINC:   i_reg <= i_reg + SW'(1);
            msr_pkg::OP_MSET:   m_reg <= i_reg;
            msr_pkg::OP_FZERO1:
            begin
                ans_root_reg  <= '0;
                ans_found_reg <= 1'b1;
            end
            msr_pkg::OP_FZERO0:
            begin
                ans_root_reg  <= '0;
                ans_found_reg <= 1'b0;
            end
            msr_pkg::OP_FN:
            begin
                ans_root_reg  <= n_reg;
                ans_found_reg <= 1'b1;
            end
            msr_pkg::OP_FRES:
            begin
                ans_root_reg  <= u_res;
                ans_found_reg <= 1'b1;
            end
            msr_pkg::OP_FR:
            begin
                ans_root_reg  <= r_reg;
                ans_found_reg <= 1'b1;
            end
            msr_pkg::OP_EMIT:
            begin
                out_root_reg  <= ans_root_reg;
                out_found_reg <= ans_found_reg;
            end
            default:
            begin
            end
        endcase
        // unit result writeback
        if (u_done)
        begin
            case (dest_reg) inside
                msr_pkg::OP_RED:                   n_reg  <= u_res;
                msr_pkg::OP_POWC, msr_pkg::OP_MBB: c_reg  <= u_res;
                msr_pkg::OP_POWR, msr_pkg::OP_MRB: r_reg  <= u_res;
                msr_pkg::OP_POWT, msr_pkg::OP_MTC: t_reg  <= u_res;
                msr_pkg::OP_SQT, msr_pkg::OP_SQT2: t2_reg <= u_res;
                msr_pkg::OP_POWB:                  b_reg  <= u_res;
                default:
                begin
                end
            endcase
        end
    end

    // status to the controller
    always_comb
    begin
        status.unit_done = u_done;
        status.res_one   = (u_res == WIDTH'(1));
        status.res_pm1   = (u_res == p_reg - WIDTH'(1));
        status.p_lt2     = (p_reg < WIDTH'(2));
        status.p_eq2     = (p_reg == WIDTH'(2));
        status.p_mod3    = (p_reg[1:0] == 2'b11);
        status.n_zero    = (n_reg == '0);
        status.q_shift   = (q_reg != '0) && !q_reg[0];
        status.z_ge_p    = (z_reg >= p_reg);
        status.t_one     = (t_reg == WIDTH'(1));
        status.t2_one    = (t2_reg == WIDTH'(1));
        status.i_lt_m    = (i_reg < m_reg);
    end

    assign out_root  = out_root_reg;
    assign out_found = out_found_reg;

endmodule

// File: src/msr_ctrl.sv
module msr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  msr_pkg::status_t status,
    output msr_pkg::cmd_t    cmd
);

    msr_pkg::st_t state_reg;
    msr_pkg::st_t state_next;
    msr_pkg::st_t ret_reg;
    msr_pkg::st_t ret_next;
    logic         out_valid_reg;
    logic         slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            msr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = msr_pkg::ST_CHK;
                end
            end
            msr_pkg::ST_CHK:
            begin
                if (status.p_lt2)
                begin
                    state_next = msr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = msr_pkg::ST_WAIT;
                    ret_next   = msr_pkg::ST_ZERO;
                end
            end
            msr_pkg::ST_WAIT:
            begin
                if (status.unit_done)
                begin
                    state_next = ret_reg;
                end
            end
            msr_pkg::ST_ZERO:
            begin
                if (status.n_zero || status.p_eq2)
                begin
                    state_next = msr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = msr_pkg::ST_WAIT;
                    ret_next   = msr_pkg::ST_EULER;
                end
            end
            msr_pkg::ST_EULER:
            begin
                if (!status.res_one)
                begin
                    state_next = msr_pkg::ST_EMIT;
                end
                else if (status.p_mod3)
                begin
                    state_next = msr_pkg::ST_WAIT;
                    ret_next   = msr_pkg::ST_ROOT34;
                end
                else
                begin
                    state_next = msr_pkg::ST_QLOOP;
                end
            end
            msr_pkg::ST_ROOT34: state_next = msr_pkg::ST_EMIT;
            msr_pkg::ST_QLOOP:
            begin
                if (!status.q_shift)
                begin
                    state_next = msr_pkg::ST_ZLOOP;
                end
            end
            msr_pkg::ST_ZLOOP:
            begin
                if (status.z_ge_p)
                begin
                    state_next = msr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = msr_pkg::ST_WAIT;
                    ret_next   = msr_pkg::ST_ZTEST;
                end
            end
            msr_pkg::ST_ZTEST:
            begin
                state_next = status.res_pm1 ? msr_pkg::ST_SETUP_C : msr_pkg::ST_ZLOOP;
            end
            msr_pkg::ST_SETUP_C:
            begin
                state_next = msr_pkg::ST_WAIT;
                ret_next   = msr_pkg::ST_SETUP_R;
            end
            msr_pkg::ST_SETUP_R:
            begin
                state_next = msr_pkg::ST_WAIT;
                ret_next   = msr_pkg::ST_SETUP_T;
            end
            msr_pkg::ST_SETUP_T:
            begin
                state_next = msr_pkg::ST_WAIT;
                ret_next   = msr_pkg::ST_OUTER;
            end
            msr_pkg::ST_OUTER:
            begin
                state_next = status.t_one ? msr_pkg::ST_EMIT : msr_pkg::ST_SQ;
            end
            msr_pkg::ST_SQ:
            begin
                state_next = msr_pkg::ST_WAIT;
                ret_next   = msr_pkg::ST_INNER;
            end
            msr_pkg::ST_INNER:
            begin
                if (!status.t2_one && status.i_lt_m)
                begin
                    state_next = msr_pkg::ST_WAIT;
                    ret_next   = msr_pkg::ST_IINC;
                end
                else if (!status.i_lt_m)
                begin
                    state_next = msr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = msr_pkg::ST_WAIT;
                    ret_next   = msr_pkg::ST_UPD_R;
                end
            end
            msr_pkg::ST_IINC:   state_next = msr_pkg::ST_INNER;
            msr_pkg::ST_UPD_R:
            begin
                state_next = msr_pkg::ST_WAIT;
                ret_next   = msr_pkg::ST_UPD_C;
            end
            msr_pkg::ST_UPD_C:
            begin
                state_next = msr_pkg::ST_WAIT;
                ret_next   = msr_pkg::ST_UPD_T;
            end
            msr_pkg::ST_UPD_T:
            begin
                state_next = msr_pkg::ST_WAIT;
                ret_next   = msr_pkg::ST_MSET;
            end
            msr_pkg::ST_MSET:   state_next = msr_pkg::ST_OUTER;
            msr_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = msr_pkg::ST_IDLE;
                end
            end
            default:            state_next = msr_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op = msr_pkg::OP_NONE;
        unique case (state_reg)
            msr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = msr_pkg::OP_LOAD;
                end
            end
            msr_pkg::ST_CHK:
            begin
                cmd.op = status.p_lt2 ? msr_pkg::OP_FZERO1 : msr_pkg::OP_RED;
            end
            msr_pkg::ST_ZERO:
            begin
                if (status.n_zero)
                begin
                    cmd.op = msr_pkg::OP_FZERO1;
                end
                else if (status.p_eq2)
                begin
                    cmd.op = msr_pkg::OP_FN;
                end
                else
                begin
                    cmd.op = msr_pkg::OP_EUL;
                end
            end
            msr_pkg::ST_EULER:
            begin
                if (!status.res_one)
                begin
                    cmd.op = msr_pkg::OP_FZERO0;
                end
                else if (status.p_mod3)
                begin
                    cmd.op = msr_pkg::OP_P34;
                end
                else
                begin
                    cmd.op = msr_pkg::OP_QINIT;
                end
            end
            msr_pkg::ST_ROOT34: cmd.op = msr_pkg::OP_FRES;
            msr_pkg::ST_QLOOP:
            begin
                cmd.op = status.q_shift ? msr_pkg::OP_QSHIFT : msr_pkg::OP_ZINIT;
            end
            msr_pkg::ST_ZLOOP:
            begin
                cmd.op = status.z_ge_p ? msr_pkg::OP_FZERO0 : msr_pkg::OP_ZCHK;
            end
            msr_pkg::ST_ZTEST:
            begin
                cmd.op = status.res_pm1 ? msr_pkg::OP_MINIT : msr_pkg::OP_ZINC;
            end
            msr_pkg::ST_SETUP_C: cmd.op = msr_pkg::OP_POWC;
            msr_pkg::ST_SETUP_R: cmd.op = msr_pkg::OP_POWR;
            msr_pkg::ST_SETUP_T: cmd.op = msr_pkg::OP_POWT;
            msr_pkg::ST_OUTER:
            begin
                cmd.op = status.t_one ? msr_pkg::OP_FR : msr_pkg::OP_IINIT;
            end
            msr_pkg::ST_SQ:     cmd.op = msr_pkg::OP_SQT;
            msr_pkg::ST_INNER:
            begin
                if (!status.t2_one && status.i_lt_m)
                begin
                    cmd.op = msr_pkg::OP_SQT2;
                end
                else if (!status.i_lt_m)
                begin
                    cmd.op = msr_pkg::OP_FZERO0;
                end
                else
                begin
                    cmd.op = msr_pkg::OP_POWB;
                end
            end
            msr_pkg::ST_IINC:   cmd.op = msr_pkg::OP_IINC;
            msr_pkg::ST_UPD_R:  cmd.op = msr_pkg::OP_MRB;
            msr_pkg::ST_UPD_C:  cmd.op = msr_pkg::OP_MBB;
            msr_pkg::ST_UPD_T:  cmd.op = msr_pkg::OP_MTC;
            msr_pkg::ST_MSET:   cmd.op = msr_pkg::OP_MSET;
            msr_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.op = msr_pkg::OP_EMIT;
                end
            end
            default:            cmd.op = msr_pkg::OP_NONE;
        endcase
    end

    // state and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msr_pkg::ST_IDLE;
            ret_reg       <= msr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if ((state_reg == msr_pkg::ST_EMIT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == msr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: src/modular_square_root.sv
// Modular square root (Tonelli-Shanks): each input word gives one output word with a root x,
// x*x = value mod p, and has_root, or root 0 with has_root 0 for a non-residue. p is taken
// from the configuration channel (reset 7) and may only change while no word is in flight.
// One word is worked on at a time; the next is accepted once the result sits in the output
// register. All arithmetic runs through one bit-serial modular multiplier; an exponentiation
// costs up to about 2*WIDTH products. A modulus of 3 mod 4 needs two exponentiations; other
// moduli add one exponentiation per candidate tested, three for setup, and per round a few
// products plus one exponentiation.
module modular_square_root #(
    parameter int WIDTH = msr_pkg::DEF_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [WIDTH-1:0]                     cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // value
    input  logic [((WIDTH + 7) / 8) * 8 - 1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // root
    output logic [((WIDTH + 7) / 8) * 8 - 1:0]  m_axis_tdata,
    // has_root
    output logic                                 m_axis_tuser
);

    localparam int TW = ((WIDTH + 7) / 8) * 8;

    msr_pkg::cmd_t    cmd;
    msr_pkg::status_t status;
    logic [WIDTH-1:0] root;

    assign cfg_ready = 1'b1;

    msr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    msr_datapath #(.WIDTH(WIDTH)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_value (cfg_data),
        .in_value  (s_axis_tdata[WIDTH-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_root  (root),
        .out_found (m_axis_tuser)
    );

    // zero fill to whole bytes
    assign m_axis_tdata = TW'(root);

endmodule
